// ===== rtl/bsr_pkg.sv =====
// Package: shared constants, widths and codes for the BSR conj-transpose SpMV unit.
`default_nettype none
package bsr_pkg;
    localparam int MAX_DIM_DEF   = 1024;
    localparam int MAX_BLOCK_DEF = 8;

    localparam int DW  = 32;
    localparam int CW  = 2 * DW;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [1:0] FUNC_LOAD_X = 2'd0;
    localparam logic [1:0] FUNC_LOAD_Y = 2'd1;
    localparam logic [1:0] FUNC_ELEM   = 2'd2;
    localparam logic [1:0] FUNC_READ_Y = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LAYOUT  = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [CFG_AW-1:0] REG_BLOCK_SIZE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LAYOUT     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_NUM_ROWS   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_NUM_COLS   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_ALPHA_RE   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_ALPHA_IM   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_BETA_RE    = 3'd6;
    localparam logic [CFG_AW-1:0] REG_BETA_IM    = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  vec_index;
        logic [9:0]  block_row;
        logic [9:0]  block_col;
        logic [5:0]  elem_pos;
        logic signed [31:0] val_re;
        logic signed [31:0] val_im;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_re;
        logic signed [31:0] out_im;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [CFG_AW-1:0] index;
        logic [CFG_DW-1:0] data;
    } t_cfg_item;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)       r = 32'sh7fffffff;
        else if (v < -34'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/bsr_if.sv =====
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface bsr_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bsr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module bsr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/bsr_cmul.sv =====
// Shared complex multiplier: four 33x33 products in sequence, Q16.16 round and saturate.
`default_nettype none
module bsr_cmul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_ar,
    input  wire logic signed [32:0] i_ai,
    input  wire logic signed [32:0] i_br,
    input  wire logic signed [32:0] i_bi,
    output logic                    o_done,
    output logic signed [31:0]      o_rr,
    output logic signed [31:0]      o_ri
);
    import bsr_pkg::*;

    logic [2:0]          r_step;
    logic signed [32:0]  r_ar, r_ai, r_br, r_bi;
    logic signed [65:0]  r_prod;
    logic signed [67:0]  r_acc_re, r_acc_im;
    logic signed [32:0]  s_a, s_b;
    logic signed [67:0]  s_rnd_re, s_rnd_im;
    logic signed [51:0]  s_q_re, s_q_im;

    // step 1..4 computes one product; each product is accumulated in the following step
    always_comb begin
        case (r_step)
            3'd1:    begin s_a = r_ar; s_b = r_br; end
            3'd2:    begin s_a = r_ai; s_b = r_bi; end
            3'd3:    begin s_a = r_ar; s_b = r_bi; end
            3'd4:    begin s_a = r_ai; s_b = r_br; end
            default: begin s_a = r_ar; s_b = r_br; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_step <= 3'd1;
                r_ar <= i_ar; r_ai <= i_ai; r_br <= i_br; r_bi <= i_bi;
                r_acc_re <= '0;
                r_acc_im <= '0;
            end else if (r_step != 3'd0) begin
                r_step <= (r_step == 3'd5) ? 3'd0 : r_step + 3'd1;
                case (r_step)
                    3'd2:    r_acc_re <= r_acc_re + 68'(r_prod);
                    3'd3:    r_acc_re <= r_acc_re - 68'(r_prod);
                    3'd4:    r_acc_im <= r_acc_im + 68'(r_prod);
                    3'd5:    r_acc_im <= r_acc_im + 68'(r_prod);
                    default: ;
                endcase
                if (r_step == 3'd5) o_done <= 1'b1;
            end
            r_prod <= s_a * s_b;
        end
    end

    // floor((sum + 2^15) / 2^16) then saturate; output valid when o_done
    always_comb begin
        s_rnd_re = r_acc_re + 68'sd32768;
        s_rnd_im = r_acc_im + 68'sd32768;
        s_q_re = s_rnd_re[67:16];
        s_q_im = s_rnd_im[67:16];
        if (s_q_re > 52'sd2147483647)       o_rr = 32'sh7fffffff;
        else if (s_q_re < -52'sd2147483648) o_rr = 32'sh80000000;
        else                                o_rr = s_q_re[31:0];
        if (s_q_im > 52'sd2147483647)       o_ri = 32'sh7fffffff;
        else if (s_q_im < -52'sd2147483648) o_ri = 32'sh80000000;
        else                                o_ri = s_q_im[31:0];
    end
endmodule
`default_nettype wire

// ===== rtl/bsr_conj_trans_spmv_unit.sv =====
// Top level: BSR conjugate-transpose sparse matrix-vector multiply unit.
// One item is worked on at a time, through these states: load-x DECODE, RD;
// read-y DECODE, RD, RDW; load-y DECODE, RD, YLD (one pass of the shared
// complex multiplier); matrix element DECODE, RD, RDW, MUL1, MUL2, YRD (two
// chained multiplier passes), then ACC (the y read-modify-write); each ends
// in OUT. An item rejected on its index or on the layout leaves from DECODE,
// an element whose x or y index falls outside the vectors from RDW. A new
// item is taken only once the previous result is in the output register.
// x and y live in two single-port RAMs with registered reads. The result
// waits in an output register, so a stalled receiver only holds the block
// up once a second result is ready. No clearing pass after reset.
`default_nettype none
module bsr_conj_trans_spmv_unit #(
    parameter int MAX_DIM   = bsr_pkg::MAX_DIM_DEF,
    parameter int MAX_BLOCK = bsr_pkg::MAX_BLOCK_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bsr_if.sink       i_in,
    bsr_if.source     o_out,
    bsr_if.sink       i_cfg
);
    import bsr_pkg::*;

    localparam int AW = $clog2(MAX_DIM);
    localparam int IW = 21; // wide enough for block index * size + offset

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_RDW   = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_YRD   = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_YLD   = 4'd8;
    localparam logic [3:0] S_DECODE = 4'd9;

    // quotient (top 3 bits) and remainder of a position by the block size;
    // three compare-subtract steps, enough for any position inside a block
    function automatic logic [8:0] pos_divmod(input logic [5:0] pos, input logic [3:0] bs);
        logic [9:0] rem;
        logic [2:0] q;
        rem = {4'd0, pos};
        q = 3'd0;
        for (int i = 2; i >= 0; i--) begin
            if (rem >= ({6'd0, bs} << i)) begin
                rem = rem - ({6'd0, bs} << i);
                q[i] = 1'b1;
            end
        end
        return {q, rem[5:0]};
    endfunction

    logic [3:0]  r_block_size;
    logic [1:0]  r_layout;
    logic [10:0] r_num_rows, r_num_cols;
    logic signed [31:0] r_alpha_re, r_alpha_im, r_beta_re, r_beta_im;

    logic [3:0] r_state;
    t_in_item   r_item;
    t_out_item  r_res;
    t_out_item  r_out;
    logic       r_out_valid;
    logic [IW-1:0] r_xi, r_yi;
    logic [5:0] r_r, r_c;
    logic signed [31:0] r_tr, r_ti;

    logic        s_xwe, s_ywe;
    logic [AW-1:0] s_xaddr, s_yaddr;
    logic [CW-1:0] s_xw, s_yw, s_xr, s_yr;
    logic          s_mstart, s_mdone;
    logic signed [32:0] s_ar, s_ai, s_br, s_bi;
    logic signed [31:0] s_rr, s_ri;
    logic [IW-1:0] s_rows, s_cols;
    logic [3:0]    s_bs;
    logic signed [33:0] s_sum_re, s_sum_im;
    logic [8:0]    s_pos_qr;
    logic          s_out_load;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= 4'd1;
            r_layout     <= 2'd0;
            r_num_rows   <= 11'd1024;
            r_num_cols   <= 11'd1024;
            r_alpha_re   <= 32'sd65536;
            r_alpha_im   <= '0;
            r_beta_re    <= '0;
            r_beta_im    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_BLOCK_SIZE: r_block_size <= i_cfg.data.data[3:0];
                REG_LAYOUT:     r_layout     <= i_cfg.data.data[1:0];
                REG_NUM_ROWS:   r_num_rows   <= i_cfg.data.data[10:0];
                REG_NUM_COLS:   r_num_cols   <= i_cfg.data.data[10:0];
                REG_ALPHA_RE:   r_alpha_re   <= i_cfg.data.data;
                REG_ALPHA_IM:   r_alpha_im   <= i_cfg.data.data;
                REG_BETA_RE:    r_beta_re    <= i_cfg.data.data;
                REG_BETA_IM:    r_beta_im    <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    // effective lengths and block size (capped)
    always_comb begin
        s_rows = (IW'(r_num_rows) < IW'(MAX_DIM)) ? IW'(r_num_rows) : IW'(MAX_DIM);
        s_cols = (IW'(r_num_cols) < IW'(MAX_DIM)) ? IW'(r_num_cols) : IW'(MAX_DIM);
        s_bs   = (32'(r_block_size) < MAX_BLOCK) ? r_block_size : 4'(MAX_BLOCK);
    end

    assign s_pos_qr = pos_divmod(r_item.elem_pos, s_bs);

    bsr_ram #(.WIDTH(CW), .DEPTH(MAX_DIM)) u_xram (
        .i_clk(i_clk), .i_we(s_xwe), .i_waddr(s_xaddr), .i_wdata(s_xw),
        .i_raddr(s_xaddr), .o_rdata(s_xr));
    bsr_ram #(.WIDTH(CW), .DEPTH(MAX_DIM)) u_yram (
        .i_clk(i_clk), .i_we(s_ywe), .i_waddr(s_yaddr), .i_wdata(s_yw),
        .i_raddr(s_yaddr), .o_rdata(s_yr));

    bsr_cmul u_cmul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_mstart),
        .i_ar(s_ar), .i_ai(s_ai), .i_br(s_br), .i_bi(s_bi),
        .o_done(s_mdone), .o_rr(s_rr), .o_ri(s_ri));

    assign s_sum_re = 34'(signed'(s_yr[63:32])) + 34'(r_tr);
    assign s_sum_im = 34'(signed'(s_yr[31:0]))  + 34'(r_ti);

    always_comb begin
        s_xwe = 1'b0;
        s_ywe = 1'b0;
        s_xaddr = AW'(r_item.vec_index);
        s_yaddr = AW'(r_item.vec_index);
        s_xw = {r_item.val_re, r_item.val_im};
        s_yw = {s_rr, s_ri};
        s_mstart = 1'b0;
        s_ar = 33'(r_item.val_re);
        s_ai = 33'(r_item.val_im);
        s_br = 33'(r_beta_re);
        s_bi = 33'(r_beta_im);
        case (r_state)
            S_RD: begin
                s_xwe = (r_item.func == FUNC_LOAD_X);
                s_mstart = (r_item.func == FUNC_LOAD_Y);
            end
            S_YLD: s_ywe = s_mdone;
            S_MUL1: begin
                s_xaddr = r_xi[AW-1:0];
                s_mstart = 1'b1;
                s_ar = 33'(r_alpha_re);
                s_ai = 33'(r_alpha_im);
                s_br = 33'(r_item.val_re);
                s_bi = -33'(r_item.val_im);
            end
            S_MUL2: begin
                s_xaddr = r_xi[AW-1:0];
                s_mstart = s_mdone;
                s_ar = 33'(s_rr);
                s_ai = 33'(s_ri);
                s_br = 33'(signed'(s_xr[63:32]));
                s_bi = 33'(signed'(s_xr[31:0]));
            end
            S_YRD: s_yaddr = r_yi[AW-1:0];
            S_ACC: begin
                s_yaddr = r_yi[AW-1:0];
                s_ywe = 1'b1;
                s_yw = {sat34(s_sum_re), sat34(s_sum_im)};
            end
            default: ;
        endcase
    end

    // a finished item moves into the output register once that is empty or being read out
    assign s_out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_in.valid && i_in.ready) begin
                    r_item <= i_in.data;
                    r_res <= '{out_re: '0, out_im: '0, status: ST_OK};
                    r_state <= S_DECODE;
                end
                S_DECODE: begin
                    // r/c split of elem_pos by the small block size
                    r_r <= 6'(s_pos_qr[8:6]);
                    r_c <= s_pos_qr[5:0];
                    r_state <= S_RD;
                    case (r_item.func)
                        FUNC_LOAD_X: if (IW'(r_item.vec_index) >= s_rows) begin
                            r_res.status <= ST_RANGE; r_state <= S_OUT;
                        end
                        FUNC_LOAD_Y, FUNC_READ_Y:
                            if (IW'(r_item.vec_index) >= s_cols) begin
                                r_res.status <= ST_RANGE; r_state <= S_OUT;
                            end
                        default: begin
                            if (r_layout > 2'd1) begin
                                r_res.status <= ST_LAYOUT; r_state <= S_OUT;
                            end else if (s_bs == 0 || 8'(r_item.elem_pos) >=
                                         8'(s_bs) * 8'(s_bs)) begin
                                r_res.status <= ST_RANGE; r_state <= S_OUT;
                            end
                        end
                    endcase
                end
                S_RD: begin
                    case (r_item.func)
                        FUNC_LOAD_X: r_state <= S_OUT;
                        FUNC_LOAD_Y: r_state <= S_YLD;
                        FUNC_READ_Y: r_state <= S_RDW;
                        default: begin
                            if (r_layout == 2'd0) begin
                                r_xi <= IW'(r_item.block_row) * IW'(s_bs) + IW'(r_r);
                                r_yi <= IW'(r_item.block_col) * IW'(s_bs) + IW'(r_c);
                            end else begin
                                r_xi <= IW'(r_item.block_row) * IW'(s_bs) + IW'(r_c);
                                r_yi <= IW'(r_item.block_col) * IW'(s_bs) + IW'(r_r);
                            end
                            r_state <= S_RDW;
                        end
                    endcase
                end
                S_RDW: begin
                    if (r_item.func == FUNC_READ_Y) begin
                        r_res.out_re <= s_yr[63:32];
                        r_res.out_im <= s_yr[31:0];
                        r_state <= S_OUT;
                    end else if (r_xi >= s_rows || r_yi >= s_cols) begin
                        r_res.status <= ST_RANGE; r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL1;
                    end
                end
                S_YLD:  if (s_mdone) r_state <= S_OUT;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: if (s_mdone) r_state <= S_YRD;
                S_YRD:  if (s_mdone) begin
                    r_tr <= s_rr; r_ti <= s_ri; r_state <= S_ACC;
                end
                S_ACC:  r_state <= S_OUT;
                S_OUT: if (s_out_load) begin
                    r_out <= r_res;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sim/bsr_conj_trans_spmv_unit_test.sv =====
// Testbench for the BSR conjugate-transpose SpMV unit: directed table, then random phases.
`timescale 1ns / 1ps
module bsr_conj_trans_spmv_unit_test;
    import bsr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int DIM            = 1024;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bsr_if #(.T(t_in_item))  in_ch ();
    bsr_if #(.T(t_out_item)) out_ch ();
    bsr_if #(.T(t_cfg_item)) cfg_ch ();

    bsr_conj_trans_spmv_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the block's registers and vector stores
    logic [3:0]         sh_bs;
    logic [1:0]         sh_layout;
    logic [10:0]        sh_rows, sh_cols;
    logic signed [31:0] sh_alpha_re, sh_alpha_im, sh_beta_re, sh_beta_im;
    logic signed [31:0] x_re [DIM];
    logic signed [31:0] x_im [DIM];
    logic signed [31:0] y_re [DIM];
    logic signed [31:0] y_im [DIM];
    bit                 x_set [DIM];
    bit                 y_set [DIM];

    t_out_item pending_y_q [$];
    int n_items, n_results, n_errors, n_status_err, n_elem_ok;
    int hold_reqs, holds_done;
    bit tx_idle_on, rx_idle_on;

    function automatic logic signed [31:0] sat_q(input logic signed [67:0] v);
        if (v > 68'sd2147483647)       return 32'sh7fffffff;
        else if (v < -68'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    // Q16.16 complex multiply, round half up, saturate each part
    task automatic cmul_q(input logic signed [32:0] ar, ai, br, bi,
                          output logic signed [31:0] rr, ri);
        logic signed [67:0] a_r, a_i, b_r, b_i, s;
        a_r = ar; a_i = ai; b_r = br; b_i = bi;
        s = (a_r * b_r - a_i * b_i + 68'sd32768) >>> 16;
        rr = sat_q(s);
        s = (a_r * b_i + a_i * b_r + 68'sd32768) >>> 16;
        ri = sat_q(s);
    endtask

    function automatic int eff_rows();
        return (sh_rows > DIM) ? DIM : int'(sh_rows);
    endfunction

    function automatic int eff_cols();
        return (sh_cols > DIM) ? DIM : int'(sh_cols);
    endfunction

    // status of an item against the current settings, plus the x/y entries it touches
    function automatic void classify(input t_in_item it, output logic [1:0] st,
                                     output int xi, yi);
        int bs, r, c;
        bs = (sh_bs > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : int'(sh_bs);
        st = ST_OK; xi = 0; yi = 0;
        case (it.func)
            FUNC_LOAD_X: begin
                xi = int'(it.vec_index);
                if (xi >= eff_rows()) st = ST_RANGE;
            end
            FUNC_LOAD_Y, FUNC_READ_Y: begin
                yi = int'(it.vec_index);
                if (yi >= eff_cols()) st = ST_RANGE;
            end
            default: begin
                if (sh_layout > 1) begin
                    st = ST_LAYOUT;
                end else if (bs == 0 || it.elem_pos >= bs * bs) begin
                    st = ST_RANGE;
                end else begin
                    if (sh_layout == 0) begin
                        r = it.elem_pos / bs; c = it.elem_pos % bs;
                    end else begin
                        c = it.elem_pos / bs; r = it.elem_pos % bs;
                    end
                    xi = it.block_row * bs + r;
                    yi = it.block_col * bs + c;
                    if (xi >= eff_rows() || yi >= eff_cols()) st = ST_RANGE;
                end
            end
        endcase
    endfunction

    function automatic bit reads_unset(input t_in_item it);
        logic [1:0] st;
        int xi, yi;
        classify(it, st, xi, yi);
        if (st != ST_OK) return 1'b0;
        if (it.func == FUNC_READ_Y) return !y_set[yi];
        if (it.func == FUNC_ELEM)   return !x_set[xi] || !y_set[yi];
        return 1'b0;
    endfunction

    task automatic apply_spmv_item(input t_in_item it, output t_out_item res);
        logic [1:0] st;
        int xi, yi;
        logic signed [31:0] tr, ti, pr, pi;
        classify(it, st, xi, yi);
        res = '0;
        res.status = st;
        if (st == ST_OK) begin
            case (it.func)
                FUNC_LOAD_X: begin
                    x_re[xi] = it.val_re; x_im[xi] = it.val_im; x_set[xi] = 1'b1;
                end
                FUNC_LOAD_Y: begin
                    cmul_q(it.val_re, it.val_im, sh_beta_re, sh_beta_im, y_re[yi], y_im[yi]);
                    y_set[yi] = 1'b1;
                end
                FUNC_ELEM: begin
                    cmul_q(sh_alpha_re, sh_alpha_im, it.val_re, -33'(it.val_im), tr, ti);
                    cmul_q(tr, ti, x_re[xi], x_im[xi], pr, pi);
                    y_re[yi] = sat_q(68'(y_re[yi]) + 68'(pr));
                    y_im[yi] = sat_q(68'(y_im[yi]) + 68'(pi));
                    n_elem_ok++;
                end
                default: begin
                    res.out_re = y_re[yi]; res.out_im = y_im[yi];
                end
            endcase
        end else begin
            n_status_err++;
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stop offering items, then wait until every expected result has come
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_y_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
        drain_results();
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_BLOCK_SIZE: sh_bs       = val[3:0];
            REG_LAYOUT:     sh_layout   = val[1:0];
            REG_NUM_ROWS:   sh_rows     = val[10:0];
            REG_NUM_COLS:   sh_cols     = val[10:0];
            REG_ALPHA_RE:   sh_alpha_re = val;
            REG_ALPHA_IM:   sh_alpha_im = val;
            REG_BETA_RE:    sh_beta_re  = val;
            default:        sh_beta_im  = val;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // send one item; a typed expectation replaces the predicted one when given
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        int gap;
        @(negedge i_clk);
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge i_clk); while (!in_ch.ready);
        apply_spmv_item(it, res);
        pending_y_q.push_back(typed ? typed_res : res);
        n_items++;
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 32'h3ffff) - 32'h20000;
            2:       return $urandom_range(0, 32'h3fffff) - 32'h200000;
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int bs, xi, yi, roll, rows, cols;
        bit found;
        it = '{func: FUNC_LOAD_X, vec_index: '0, block_row: '0, block_col: '0,
               elem_pos: '0, val_re: rand_val(), val_im: rand_val()};
        rows = eff_rows(); cols = eff_cols();
        bs = (sh_bs > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : int'(sh_bs);
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            // noise: any field pattern
            it.func = 2'($urandom_range(0, 3));
            it.vec_index = 10'($urandom()); it.block_row = 10'($urandom());
            it.block_col = 10'($urandom()); it.elem_pos = 6'($urandom());
        end else if (roll < 25) begin
            it.func = FUNC_LOAD_X;
            it.vec_index = ($urandom_range(0, 15) == 0) ? 10'($urandom())
                                                        : 10'($urandom_range(0, rows - 1));
        end else if (roll < 38) begin
            it.func = FUNC_LOAD_Y;
            it.vec_index = ($urandom_range(0, 15) == 0) ? 10'($urandom())
                                                        : 10'($urandom_range(0, cols - 1));
        end else if (roll < 55) begin
            it.func = FUNC_READ_Y;
            it.vec_index = 10'($urandom_range(0, cols - 1));
        end else begin
            it.func = FUNC_ELEM;
            found = 1'b0;
            if (bs > 0) begin
                for (int k = 0; k < 24 && !found; k++) begin
                    xi = $urandom_range(0, rows - 1);
                    yi = $urandom_range(0, cols - 1);
                    found = x_set[xi] && y_set[yi];
                end
            end
            if (found) begin
                it.block_row = 10'(xi / bs); it.block_col = 10'(yi / bs);
                it.elem_pos = (sh_layout == 1) ? 6'((yi % bs) * bs + xi % bs)
                                               : 6'((xi % bs) * bs + yi % bs);
            end else begin
                it.block_row = 10'($urandom_range(0, 3));
                it.block_col = 10'($urandom_range(0, 3));
                it.elem_pos = 6'($urandom());
            end
        end
        if (reads_unset(it)) begin
            it.func = $urandom_range(0, 1) ? FUNC_LOAD_X : FUNC_LOAD_Y;
            it.vec_index = (it.func == FUNC_LOAD_X) ? 10'($urandom_range(0, rows - 1))
                                                    : 10'($urandom_range(0, cols - 1));
        end
        return it;
    endfunction

    typedef struct {
        bit                 is_reg;
        logic [CFG_AW-1:0]  reg_idx;
        logic [31:0]        reg_val;
        t_in_item           it;
        bit                 typed;
        t_out_item          res;
    } t_step;

    function automatic t_step it_row(input logic [1:0] f, input int vi, br, bc, pos,
                                     input logic [31:0] vr, vim);
        t_step s;
        s = '{default: '0};
        s.it = '{func: f, vec_index: 10'(vi), block_row: 10'(br), block_col: 10'(bc),
                 elem_pos: 6'(pos), val_re: vr, val_im: vim};
        return s;
    endfunction

    function automatic t_step typed_row(input t_step s, input logic [31:0] ore, oim,
                                        input logic [1:0] st);
        s.typed = 1'b1;
        s.res = '{out_re: ore, out_im: oim, status: st};
        return s;
    endfunction

    function automatic t_step reg_row(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
        t_step s;
        s = '{default: '0};
        s.is_reg = 1'b1; s.reg_idx = idx; s.reg_val = val;
        return s;
    endfunction

    typedef struct {
        logic [3:0]  bs;
        logic [1:0]  layout;
        logic [10:0] rows, cols;
        logic [31:0] ar, ai, br, bi;
        bit          hold;
        bit          idle;
    } t_phase;

    t_step  directed [$];
    t_phase phases [$];
    t_step  s;
    t_phase p;

    // output side: random stalls plus requested long holds
    int rx_gap, hold_left;
    always @(negedge i_clk) begin
        if (holds_done < hold_reqs) begin
            hold_left = LONG_HOLD;
            holds_done++;
        end
        if (hold_left > 0) begin
            out_ch.ready = 1'b0;
            hold_left--;
        end else if (!rx_idle_on) begin
            out_ch.ready = 1'b1;
        end else if (rx_gap > 0) begin
            out_ch.ready = 1'b0;
            rx_gap--;
        end else begin
            out_ch.ready = 1'b1;
            rx_gap = pick_gap();
        end
    end

    t_out_item want;
    int idle_cycles;
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (pending_y_q.size() == 0) begin
                $error("result with nothing expected: re=%0d im=%0d status=%0d",
                       out_ch.data.out_re, out_ch.data.out_im, out_ch.data.status);
                n_errors++;
            end else begin
                want = pending_y_q.pop_front();
                if (out_ch.data.out_re !== want.out_re) begin
                    $error("out_re: expected %0d, got %0d", want.out_re, out_ch.data.out_re);
                    n_errors++;
                end
                if (out_ch.data.out_im !== want.out_im) begin
                    $error("out_im: expected %0d, got %0d", want.out_im, out_ch.data.out_im);
                    n_errors++;
                end
                if (out_ch.data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_ch.data.status);
                    n_errors++;
                end
            end
        end
        if (!i_rst_n || (out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d cycles without any handshake", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0; in_ch.data = '0;
        cfg_ch.valid = 1'b0; cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        rx_gap = 0; hold_left = 0; idle_cycles = 0;
        hold_reqs = 0; holds_done = 0;
        n_items = 0; n_results = 0; n_errors = 0; n_status_err = 0; n_elem_ok = 0;
        tx_idle_on = 1'b1; rx_idle_on = 1'b1;
        sh_bs = 4'd1; sh_layout = 2'd0; sh_rows = 11'd1024; sh_cols = 11'd1024;
        sh_alpha_re = 32'sd65536; sh_alpha_im = '0; sh_beta_re = '0; sh_beta_im = '0;
        for (int i = 0; i < DIM; i++) begin
            x_re[i] = '0; x_im[i] = '0; y_re[i] = '0; y_im[i] = '0;
            x_set[i] = 1'b0; y_set[i] = 1'b0;
        end

        // reset settings: bs 1, row-major, 1024 x 1024, alpha 1, beta 0
        directed.push_back(typed_row(it_row(FUNC_LOAD_X, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000),
                                     0, 0, ST_OK));
        directed.push_back(typed_row(it_row(FUNC_LOAD_X, 1023, 1023, 1023, 63, 32'h80000000,
                                            32'h7fffffff), 0, 0, ST_OK));
        directed.push_back(typed_row(it_row(FUNC_LOAD_Y, 0, 0, 0, 0, 32'h12345678, 32'h9abcdef0),
                                     0, 0, ST_OK));
        directed.push_back(typed_row(it_row(FUNC_LOAD_Y, 1023, 0, 0, 0, 32'h7fffffff, 32'h1),
                                     0, 0, ST_OK));
        directed.push_back(typed_row(it_row(FUNC_LOAD_Y, 1, 0, 0, 0, 32'h1, 32'h80000000),
                                     0, 0, ST_OK));
        // beta is zero, so a loaded y reads back as zero
        directed.push_back(typed_row(it_row(FUNC_READ_Y, 0, 0, 0, 0, '1, '1), 0, 0, ST_OK));
        directed.push_back(it_row(FUNC_ELEM, 0, 0, 0, 0, 32'h10000, 32'h0));
        directed.push_back(it_row(FUNC_READ_Y, 0, 0, 0, 0, 0, 0));
        directed.push_back(typed_row(it_row(FUNC_ELEM, 0, 0, 0, 1, 32'h10000, 0), 0, 0, ST_RANGE));
        directed.push_back(it_row(FUNC_ELEM, 0, 1023, 1023, 0, 32'h7fffffff, 32'h80000000));
        directed.push_back(it_row(FUNC_READ_Y, 1023, 0, 0, 0, 0, 0));
        directed.push_back(reg_row(REG_LAYOUT, 32'd2));
        directed.push_back(typed_row(it_row(FUNC_ELEM, 0, 0, 0, 0, 1, 1), 0, 0, ST_LAYOUT));
        directed.push_back(reg_row(REG_LAYOUT, 32'd1));
        directed.push_back(reg_row(REG_BLOCK_SIZE, 32'd2));
        // column-major, bs 2: pos 2 is inner column 1, inner row 0
        directed.push_back(it_row(FUNC_ELEM, 0, 0, 0, 2, 32'h8000, 32'hffff8000));
        directed.push_back(typed_row(it_row(FUNC_ELEM, 0, 0, 0, 4, 1, 1), 0, 0, ST_RANGE));
        directed.push_back(reg_row(REG_NUM_ROWS, 32'd4));
        directed.push_back(reg_row(REG_NUM_COLS, 32'd3));
        directed.push_back(typed_row(it_row(FUNC_LOAD_X, 4, 0, 0, 0, 1, 1), 0, 0, ST_RANGE));
        directed.push_back(typed_row(it_row(FUNC_READ_Y, 3, 0, 0, 0, 0, 0), 0, 0, ST_RANGE));
        directed.push_back(typed_row(it_row(FUNC_LOAD_Y, 1023, 0, 0, 0, 1, 1), 0, 0, ST_RANGE));
        directed.push_back(typed_row(it_row(FUNC_ELEM, 0, 2, 0, 0, 1, 1), 0, 0, ST_RANGE));
        directed.push_back(it_row(FUNC_READ_Y, 1, 0, 0, 0, 0, 0));

        //                bs  lay rows  cols  alpha_re      alpha_im      beta_re       beta_im
        phases.push_back('{4'd1, 2'd0, 11'd1024, 11'd1024, 32'h10000, 32'h0, 32'h10000, 32'h0,
                           1'b0, 1'b1});
        phases.push_back('{4'd2, 2'd1, 11'd16, 11'd20, $urandom_range(0, 32'h3ffff),
                           $urandom_range(0, 32'h1ffff), 32'hffff0000, 32'h8000, 1'b1, 1'b1});
        phases.push_back('{4'd8, 2'd0, 11'd64, 11'd64, 32'h7fffffff, 32'h80000000,
                           32'h80000000, 32'h7fffffff, 1'b0, 1'b0});
        phases.push_back('{4'd3, 2'd1, 11'd7, 11'd11, $urandom(), $urandom(), $urandom(),
                           $urandom(), 1'b0, 1'b1});
        phases.push_back('{4'd0, 2'd0, 11'd24, 11'd24, 32'h10000, 32'h10000, 32'h10000, 32'h0,
                           1'b0, 1'b1});
        phases.push_back('{4'd15, 2'd2, 11'd2047, 11'd1025, 32'h10000, 32'h0, 32'h8000, 32'h0,
                           1'b0, 1'b1});
        phases.push_back('{4'd5, 2'd3, 11'd1, 11'd1, 32'h10000, 32'h0, 32'h10000, 32'h0,
                           1'b0, 1'b1});
        phases.push_back('{4'd4, 2'd0, 11'd40, 11'd33, 32'h80000000, 32'h7fffffff,
                           $urandom(), $urandom(), 1'b0, 1'b1});
        phases.push_back('{4'd7, 2'd1, 11'd30, 11'd30, 32'h18000, 32'hffff4000, 32'h0,
                           32'h10000, 1'b1, 1'b1});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) begin
            s = directed[i];
            if (s.is_reg) write_reg(s.reg_idx, s.reg_val);
            else          send_item(s.it, s.typed, s.res);
        end

        foreach (phases[i]) begin
            p = phases[i];
            write_reg(REG_BLOCK_SIZE, 32'(p.bs));
            write_reg(REG_LAYOUT, 32'(p.layout));
            write_reg(REG_NUM_ROWS, 32'(p.rows));
            write_reg(REG_NUM_COLS, 32'(p.cols));
            write_reg(REG_ALPHA_RE, p.ar);
            write_reg(REG_ALPHA_IM, p.ai);
            write_reg(REG_BETA_RE, p.br);
            write_reg(REG_BETA_IM, p.bi);
            tx_idle_on = p.idle;
            rx_idle_on = p.idle;
            // long output stall while items keep coming, so the input backs up
            if (p.hold) hold_reqs++;
            for (int k = 0; k < 136; k++) begin
                if (k == 70) drain_results();
                send_item(rand_item(), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        drain_results();
        repeat (30) @(posedge i_clk);

        $display("covered %0d items over %0d settings: %0d results, %0d accumulations,",
                 n_items, phases.size() + 1, n_results, n_elem_ok);
        $display("%0d items answered with an error status", n_status_err);
        if (n_errors == 0 && pending_y_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, pending_y_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/bsr_pkg.sv
rtl/bsr_if.sv
rtl/bsr_ram.sv
rtl/bsr_cmul.sv
rtl/bsr_conj_trans_spmv_unit.sv
sim/bsr_conj_trans_spmv_unit_test.sv
